// ===== src/sti_pkg.sv =====
// Shared types and constants for the spectrum table interpolator.
`default_nettype none

package sti_pkg;

    localparam int MAX_POINTS_DEF = 64;

    localparam int PER_W     = 24;
    localparam int ACC_W     = 32;
    localparam int IDX_W     = 6;
    localparam int CNT_W     = 7;
    localparam int STAT_W    = 2;
    localparam int PROD_W    = PER_W + ACC_W;
    localparam int DIV_STEPS = ACC_W;
    localparam int DIVC_W    = $clog2(DIV_STEPS);

    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;
    localparam int REG_IX_W  = APB_AW - 2;

    localparam logic [REG_IX_W-1:0] REG_POINTS_IN_USE = REG_IX_W'(0);

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FEW   = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        SEL_OK    = 3'd0,
        SEL_FEW   = 3'd1,
        SEL_RANGE = 3'd2,
        SEL_LO    = 3'd3,
        SEL_HI    = 3'd4,
        SEL_INT   = 3'd5
    } t_res_sel;

    typedef struct packed {
        logic     latch;
        logic     mem_we;
        logic     ld_lo;
        logic     ld_hi;
        logic     ld_diff;
        logic     div_init;
        logic     div_step;
        logic     out_load;
        t_res_sel out_sel;
    } t_ctl_cmd;

    typedef struct packed {
        logic idx_bad;
        logic q_le_lo;
        logic q_ge_rd;
        logic rd_gt_q;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== src/sti_dp.sv =====
// Datapath: table memory, neighbor registers, multiplier, serial divider, output register.
`default_nettype none

module sti_dp
    import sti_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire t_ctl_cmd                      i_cmd,
    output t_dp_stat                           o_stat,
    input  wire logic [$clog2(MAX_POINTS)-1:0] i_rd_addr,
    input  wire logic [IDX_W-1:0]              i_point_index,
    input  wire logic [PER_W-1:0]              i_point_period,
    input  wire logic [ACC_W-1:0]              i_point_accel,
    input  wire logic [PER_W-1:0]              i_query_period,
    input  wire logic                          i_out_ready,
    output logic                               o_out_valid,
    output logic [ACC_W-1:0]                   o_accel_out,
    output logic [STAT_W-1:0]                  o_status
);

    localparam int AW = $clog2(MAX_POINTS);

    logic [PER_W-1:0] mem_per [MAX_POINTS];
    logic [ACC_W-1:0] mem_acc [MAX_POINTS];

    logic [IDX_W-1:0] r_idx;
    logic [PER_W-1:0] r_per;
    logic [ACC_W-1:0] r_acc;
    logic [PER_W-1:0] r_q;

    logic [PER_W-1:0] r_rd_per;
    logic [ACC_W-1:0] r_rd_acc;
    logic [PER_W-1:0] r_lo_per;
    logic [ACC_W-1:0] r_lo_acc;
    logic [PER_W-1:0] r_hi_per;
    logic [ACC_W-1:0] r_hi_acc;

    logic [PER_W-1:0] r_dq;
    logic [PER_W-1:0] r_dp;
    logic [ACC_W-1:0] r_da;
    logic             r_neg;

    logic [PER_W-1:0] r_rem;
    logic [ACC_W-1:0] r_qd;

    logic              r_ov;
    logic [ACC_W-1:0]  r_accel;
    t_status           r_status;

    logic [PROD_W-1:0] w_prod;
    logic [PER_W:0]    w_trial;
    logic [PER_W:0]    w_sub;
    logic              w_ge;
    logic [ACC_W-1:0]  n_accel;
    t_status           n_status;

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_idx <= i_point_index;
            r_per <= i_point_period;
            r_acc <= i_point_accel;
            r_q   <= i_query_period;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_we) begin
            mem_per[AW'(r_idx)] <= r_per;
            mem_acc[AW'(r_idx)] <= r_acc;
        end
        r_rd_per <= mem_per[i_rd_addr];
        r_rd_acc <= mem_acc[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_lo) begin
            r_lo_per <= r_rd_per;
            r_lo_acc <= r_rd_acc;
        end
        if (i_cmd.ld_hi) begin
            r_hi_per <= r_rd_per;
            r_hi_acc <= r_rd_acc;
        end
        if (i_cmd.ld_diff) begin
            r_dq  <= r_q - r_lo_per;
            r_dp  <= r_hi_per - r_lo_per;
            r_neg <= (r_hi_acc < r_lo_acc);
            r_da  <= (r_hi_acc < r_lo_acc) ? (r_lo_acc - r_hi_acc) : (r_hi_acc - r_lo_acc);
        end
    end

    assign w_prod = PROD_W'(r_da) * PROD_W'(r_dq);

    // restoring step: quotient bits shift in where dividend bits shift out
    assign w_trial = {r_rem, r_qd[ACC_W-1]};
    assign w_sub   = w_trial - {1'b0, r_dp};
    assign w_ge    = (w_trial >= {1'b0, r_dp});

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            // the product's upper part is below the divisor, so the quotient fits
            r_rem <= w_prod[PROD_W-1:ACC_W];
            r_qd  <= w_prod[ACC_W-1:0];
        end else if (i_cmd.div_step) begin
            r_rem <= w_ge ? w_sub[PER_W-1:0] : w_trial[PER_W-1:0];
            r_qd  <= {r_qd[ACC_W-2:0], w_ge};
        end
    end

    always_comb begin
        n_accel  = '0;
        n_status = ST_OK;
        unique case (i_cmd.out_sel)
            SEL_OK:    n_status = ST_OK;
            SEL_FEW:   n_status = ST_FEW;
            SEL_RANGE: n_status = ST_RANGE;
            SEL_LO:    n_accel  = r_lo_acc;
            SEL_HI:    n_accel  = r_hi_acc;
            SEL_INT:   n_accel  = r_neg ? (r_lo_acc - r_qd) : (r_lo_acc + r_qd);
            default:   n_status = ST_OK;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_accel  <= n_accel;
            r_status <= n_status;
        end
    end

    assign o_stat.idx_bad  = (32'(r_idx) >= 32'(MAX_POINTS));
    assign o_stat.q_le_lo  = (r_q <= r_lo_per);
    assign o_stat.q_ge_rd  = (r_q >= r_rd_per);
    assign o_stat.rd_gt_q  = (r_rd_per > r_q);
    assign o_stat.out_free = !r_ov || i_out_ready;

    assign o_out_valid = r_ov;
    assign o_accel_out = r_accel;
    assign o_status    = r_status;

endmodule

`default_nettype wire

// ===== src/sti_ctrl.sv =====
// Controller: sequences table writes, the neighbor scan, the divider and result hand-off.
`default_nettype none

module sti_ctrl
    import sti_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic                            i_req_type,
    input  wire logic [$clog2(MAX_POINTS+1)-1:0] i_n,
    input  wire t_dp_stat                        i_stat,
    output t_ctl_cmd                             o_cmd,
    output logic [$clog2(MAX_POINTS)-1:0]        o_rd_addr
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_WR   = 9'b000000010,
        S_END  = 9'b000000100,
        S_CHK  = 9'b000001000,
        S_SCAN = 9'b000010000,
        S_DIFF = 9'b000100000,
        S_MUL  = 9'b001000000,
        S_DIV  = 9'b010000000,
        S_RES  = 9'b100000000
    } t_state;

    t_state            r_state, n_state;
    logic [AW-1:0]     r_k, n_k;
    logic [DIVC_W-1:0] r_cnt, n_cnt;
    t_res_sel          r_sel, n_sel;

    logic [AW-1:0]     w_last_addr;
    logic [AW-1:0]     w_scan_last;
    logic              w_few;

    assign w_last_addr = AW'(i_n - CW'(1));
    assign w_scan_last = AW'(i_n - CW'(2));
    assign w_few       = (i_n < CW'(2));
    assign o_in_ready  = (r_state == S_IDLE);

    always_comb begin
        n_state       = r_state;
        n_k           = r_k;
        n_cnt         = r_cnt;
        n_sel         = r_sel;
        o_cmd         = '0;
        o_cmd.out_sel = r_sel;
        o_rd_addr     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    if (!i_req_type) begin
                        n_state = S_WR;
                    end else if (w_few) begin
                        n_sel   = SEL_FEW;
                        n_state = S_RES;
                    end else begin
                        n_state = S_END;
                    end
                end
            end
            S_WR: begin
                if (i_stat.idx_bad) begin
                    n_sel = SEL_RANGE;
                end else begin
                    o_cmd.mem_we = 1'b1;
                    n_sel        = SEL_OK;
                end
                n_state = S_RES;
            end
            S_END: begin
                o_cmd.ld_lo = 1'b1;
                o_rd_addr   = w_last_addr;
                n_state     = S_CHK;
            end
            S_CHK: begin
                o_cmd.ld_hi = 1'b1;
                priority if (i_stat.q_le_lo) begin
                    n_sel   = SEL_LO;
                    n_state = S_RES;
                end else if (i_stat.q_ge_rd) begin
                    n_sel   = SEL_HI;
                    n_state = S_RES;
                end else if (i_n == CW'(2)) begin
                    n_state = S_DIFF;
                end else begin
                    o_rd_addr = AW'(1);
                    n_k       = AW'(1);
                    n_state   = S_SCAN;
                end
            end
            S_SCAN: begin
                // stream the next address while comparing the entry just read
                o_rd_addr = r_k + AW'(1);
                if (i_stat.rd_gt_q) begin
                    o_cmd.ld_hi = 1'b1;
                    n_state     = S_DIFF;
                end else begin
                    o_cmd.ld_lo = 1'b1;
                    if (r_k == w_scan_last) begin
                        n_state = S_DIFF;
                    end else begin
                        n_k = r_k + AW'(1);
                    end
                end
            end
            S_DIFF: begin
                o_cmd.ld_diff = 1'b1;
                n_state       = S_MUL;
            end
            S_MUL: begin
                o_cmd.div_init = 1'b1;
                n_cnt          = '0;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + DIVC_W'(1);
                if (r_cnt == DIVC_W'(DIV_STEPS - 1)) begin
                    n_sel   = SEL_INT;
                    n_state = S_RES;
                end
            end
            S_RES: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k   <= n_k;
        r_cnt <= n_cnt;
        r_sel <= n_sel;
    end

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state != S_IDLE))
        else $error("accepted word did not start a job");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_stat.out_free)
        else $error("result loaded over an untaken word");

    a_div_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_cnt == DIVC_W'(DIV_STEPS - 1))
        |=> (r_state == S_RES && r_sel == SEL_INT))
        else $error("divider did not hand off the interpolated result");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_k <= w_scan_last))
        else $error("scan ran past the last interior point");

endmodule

`default_nettype wire

// ===== src/spectrum_table_interpolator_unit.sv =====
// Top level: APB register, controller and datapath of the table interpolator.
//
//  channel   | direction | handshake                  | payload
//  ----------+-----------+----------------------------+---------------------------------------
//  in        | to block  | i_in_valid / o_in_ready    | req_type, point_index, point_period,
//            |           |                            | point_accel, query_period
//  out       | from block| o_out_valid / i_out_ready  | accel_out, status
//  apb       | to block  | psel, penable, pready      | paddr, pwdata, prdata (points_in_use)
//
// A write word is latched, then written to the table unless its index is out of range. A query
// checks the first and last entries, then scans interior points (at most points_in_use - 2):
// one table entry is read per cycle through the single memory read port, then a 32-step
// restoring divider runs. Clamped queries skip both; too few points skip every table read.
// Reset clears the sequencer, the output valid flag and points_in_use; table contents stay.
// A new word is taken while the previous result still waits in the output register.
`default_nettype none

module spectrum_table_interpolator_unit
    import sti_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [0:0]        i_req_type,
    input  wire logic [IDX_W-1:0]  i_point_index,
    input  wire logic [PER_W-1:0]  i_point_period,
    input  wire logic [ACC_W-1:0]  i_point_accel,
    input  wire logic [PER_W-1:0]  i_query_period,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic [ACC_W-1:0]       o_accel_out,
    output logic [STAT_W-1:0]      o_status,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0]      prdata,
    output logic                   pready
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    logic [CNT_W-1:0] r_pin;
    logic [CW-1:0]    w_n;
    logic             w_hit;
    t_ctl_cmd         w_cmd;
    t_dp_stat         w_stat;
    logic [AW-1:0]    w_rd_addr;

    assign pready = 1'b1;
    assign w_hit  = (paddr[APB_AW-1:2] == REG_POINTS_IN_USE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pin <= '0;
        end else if (psel && penable && pwrite && pready && w_hit) begin
            r_pin <= pwdata[CNT_W-1:0];
        end
    end

    assign prdata = w_hit ? APB_DW'(r_pin) : '0;

    // saturate the point count to the table depth
    assign w_n = (32'(r_pin) >= 32'(MAX_POINTS)) ? CW'(MAX_POINTS) : CW'(r_pin);

    sti_ctrl #(
        .MAX_POINTS (MAX_POINTS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_req_type (i_req_type[0]),
        .i_n        (w_n),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_rd_addr  (w_rd_addr)
    );

    sti_dp #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_rd_addr      (w_rd_addr),
        .i_point_index  (i_point_index),
        .i_point_period (i_point_period),
        .i_point_accel  (i_point_accel),
        .i_query_period (i_query_period),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_accel_out    (o_accel_out),
        .o_status       (o_status)
    );

endmodule

`default_nettype wire
